### src/pds_pkg.sv
// shared widths, codes and controller/datapath interface types for the pll divider search
package pds_pkg;

    localparam int REF_W  = 16;
    localparam int MULT_W = 10;
    localparam int DIV_W  = 8;
    localparam int EXP_W  = 3;
    localparam int KHZ_W  = 32;
    localparam int STAT_W = 2;
    localparam int CFG_IDX_W = 3;

    // product reference * m and iterative divider geometry
    localparam int PROD_W     = REF_W + MULT_W;
    localparam int DIV_RADIX  = 2;
    localparam int DIV_CYCLES = PROD_W / DIV_RADIX;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

    localparam int OUT_DATA_W = MULT_W + DIV_W + EXP_W + KHZ_W;
    localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

    localparam logic [EXP_W-1:0] POST_EXP_MIN = 3'd0;

    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT_MIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT_MAX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIV_MIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIV_MAX   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POST_EXP  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_VCO_MIN   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_VCO_MAX   = 3'd7;

    localparam logic [REF_W-1:0]  RST_REFERENCE = 16'd14318;
    localparam logic [MULT_W-1:0] RST_MULT_MIN  = 10'd3;
    localparam logic [MULT_W-1:0] RST_MULT_MAX  = 10'd129;
    localparam logic [DIV_W-1:0]  RST_DIV_MIN   = 8'd3;
    localparam logic [DIV_W-1:0]  RST_DIV_MAX   = 8'd33;
    localparam logic [EXP_W-1:0]  RST_POST_EXP  = 3'd3;
    localparam logic [KHZ_W-1:0]  RST_VCO_MIN   = 32'd135000;
    localparam logic [KHZ_W-1:0]  RST_VCO_MAX   = 32'd270000;

    typedef struct packed {
        logic              load;
        logic              scale;
        logic              lower;
        logic              set_status;
        logic [STAT_W-1:0] status_code;
        logic              walk_init;
        logic              mul;
        logic              div_step;
        logic              eval;
        logic              emit;
    } pds_cmd_t;

    typedef struct packed {
        logic ovf;
        logic need_lower;
        logic out_range;
        logic empty;
        logic walk_done;
        logic div_last;
        logic out_free;
    } pds_stat_t;

endpackage

### src/pll_divider_search.sv
// top level of the pll m/n/r divider search
//
// usage: write the eight limit registers through cfg_we/cfg_index/cfg_data while
// the block is idle (index 0 reference, 1-2 m range, 3-4 n range, 5 largest r,
// 6-7 vco range). a wanted frequency in kHz enters on the s_axis channel; one
// result item leaves on m_axis with m, n, r and the achieved frequency in tdata
// and the status code in tuser.
// sequence: capture, scaling, the halvings of r followed by the checks, then for each
// m/n walk step a multiply, the 2-bit-per-cycle divider and a compare, then the
// end-of-walk check and the emit.
// the walk makes at most (mult_max-mult_min+1)+(div_max-div_min+1) steps; the single
// divider used in every step dominates the time an item takes.
// items are handled one at a time; s_axis_tready is high only when no search runs.
// the result sits in an output register, so a new item is accepted while the
// previous result waits; if the receiver stalls, the next search holds in its
// last cycle until the register is free.
// reset restores the limit registers to their defaults and empties the output.
module pll_divider_search (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // wanted_khz[31:0]
    input  logic [pds_pkg::KHZ_W-1:0]           s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // mult_out[9:0], div_out[17:10], post_exp_out[20:18], achieved_khz[52:21], zero pad
    output logic [pds_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // status[1:0]
    output logic [pds_pkg::STAT_W-1:0]          m_axis_tuser,
    input  logic                                cfg_we,
    input  logic [pds_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pds_pkg::KHZ_W-1:0]           cfg_data
);
    import pds_pkg::*;

    pds_cmd_t  cmd;
    pds_stat_t stat;

    pds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pds_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_wanted  (s_axis_tdata),
        .cmd        (cmd),
        .stat       (stat),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_data   (m_axis_tdata),
        .out_status (m_axis_tuser)
    );

endmodule

### src/pds_ctrl.sv
// sequencer for the pll divider search: scaling, r lowering, checks and m/n walk
module pds_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pds_pkg::pds_stat_t  stat,
    output pds_pkg::pds_cmd_t   cmd
);
    import pds_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCALE = 3'd1;
    localparam logic [2:0] ST_LOWER = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_EVAL  = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                if (stat.ovf)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = STATUS_RANGE;
                    state_next      = ST_EMIT;
                end
                else
                begin
                    cmd.scale  = 1'b1;
                    state_next = ST_LOWER;
                end
            end
            ST_LOWER:
            begin
                // one halving per cycle, then range and empty checks
                if (stat.need_lower)
                begin
                    cmd.lower = 1'b1;
                end
                else if (stat.out_range)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = STATUS_RANGE;
                    state_next      = ST_EMIT;
                end
                else if (stat.empty)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = STATUS_EMPTY;
                    state_next      = ST_EMIT;
                end
                else
                begin
                    cmd.walk_init = 1'b1;
                    state_next    = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (stat.walk_done)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = STATUS_OK;
                    state_next      = ST_EMIT;
                end
                else
                begin
                    cmd.mul    = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = ST_MUL;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### src/pds_dp.sv
// datapath: config registers, vco target, m/n walk with iterative divider, output register
module pds_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [pds_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pds_pkg::KHZ_W-1:0]             cfg_data,
    input  logic [pds_pkg::KHZ_W-1:0]             in_wanted,
    input  pds_pkg::pds_cmd_t                     cmd,
    output pds_pkg::pds_stat_t                    stat,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic [pds_pkg::OUT_TDATA_W-1:0]       out_data,
    output logic [pds_pkg::STAT_W-1:0]            out_status
);
    import pds_pkg::*;

    localparam int SHIFT_W = KHZ_W + (1 << EXP_W) - 1;

    // configuration
    logic [REF_W-1:0]  ref_reg;
    logic [MULT_W-1:0] mult_min_reg;
    logic [MULT_W-1:0] mult_max_reg;
    logic [DIV_W-1:0]  div_min_reg;
    logic [DIV_W-1:0]  div_max_reg;
    logic [EXP_W-1:0]  post_exp_reg;
    logic [KHZ_W-1:0]  vco_min_reg;
    logic [KHZ_W-1:0]  vco_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg      <= RST_REFERENCE;
            mult_min_reg <= RST_MULT_MIN;
            mult_max_reg <= RST_MULT_MAX;
            div_min_reg  <= RST_DIV_MIN;
            div_max_reg  <= RST_DIV_MAX;
            post_exp_reg <= RST_POST_EXP;
            vco_min_reg  <= RST_VCO_MIN;
            vco_max_reg  <= RST_VCO_MAX;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_REFERENCE: ref_reg      <= cfg_data[REF_W-1:0];
                CFG_MULT_MIN:  mult_min_reg <= cfg_data[MULT_W-1:0];
                CFG_MULT_MAX:  mult_max_reg <= cfg_data[MULT_W-1:0];
                CFG_DIV_MIN:   div_min_reg  <= cfg_data[DIV_W-1:0];
                CFG_DIV_MAX:   div_max_reg  <= cfg_data[DIV_W-1:0];
                CFG_POST_EXP:  post_exp_reg <= cfg_data[EXP_W-1:0];
                CFG_VCO_MIN:   vco_min_reg  <= cfg_data;
                CFG_VCO_MAX:   vco_max_reg  <= cfg_data;
                default:       ref_reg      <= ref_reg;
            endcase
        end
    end

    // working registers (payload, no reset)
    logic [KHZ_W-1:0]  wanted_reg;
    logic [EXP_W-1:0]  r_reg;
    logic [KHZ_W-1:0]  vco_reg;
    logic [MULT_W:0]   am_reg;
    logic [DIV_W:0]    an_reg;
    logic [MULT_W-1:0] best_m_reg;
    logic [DIV_W-1:0]  best_n_reg;
    logic [PROD_W-1:0] best_cur_reg;
    logic [KHZ_W-1:0]  best_delta_reg;
    logic              first_reg;
    logic [PROD_W-1:0] quo_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [STAT_W-1:0] code_reg;

    logic [SHIFT_W-1:0] shifted;
    logic [PROD_W-1:0]  quo_next;
    logic [DIV_W-1:0]   rem_next;
    logic [DIV_W:0]     trial;
    logic [KHZ_W-1:0]   cur;
    logic [KHZ_W-1:0]   delta;
    logic               better;

    assign shifted = {{(SHIFT_W-KHZ_W){1'b0}}, wanted_reg} << r_reg;
    assign cur     = {{(KHZ_W-PROD_W){1'b0}}, quo_reg};
    assign delta   = (cur >= vco_reg) ? (cur - vco_reg) : (vco_reg - cur);
    assign better  = first_reg || (delta < best_delta_reg);

    // restoring division, DIV_RADIX quotient bits per cycle
    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        trial    = '0;
        for (int i = 0; i < DIV_RADIX; i++)
        begin
            trial    = {rem_next, quo_next[PROD_W-1]};
            quo_next = {quo_next[PROD_W-2:0], 1'b0};
            if (trial >= {1'b0, an_reg[DIV_W-1:0]})
            begin
                rem_next    = DIV_W'(trial - {1'b0, an_reg[DIV_W-1:0]});
                quo_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            wanted_reg <= in_wanted;
            r_reg      <= post_exp_reg;
        end
        if (cmd.scale)
        begin
            vco_reg <= shifted[KHZ_W-1:0];
        end
        if (cmd.lower)
        begin
            r_reg   <= r_reg - 1'b1;
            vco_reg <= vco_reg >> 1;
        end
        if (cmd.set_status)
        begin
            code_reg <= cmd.status_code;
        end
        if (cmd.walk_init)
        begin
            am_reg     <= {1'b0, mult_min_reg};
            an_reg     <= {1'b0, div_min_reg};
            best_m_reg <= mult_min_reg;
            best_n_reg <= div_min_reg;
            first_reg  <= 1'b1;
        end
        if (cmd.mul)
        begin
            // am stays within mult_max here, so its low bits carry the value
            quo_reg     <= PROD_W'(ref_reg) * PROD_W'(am_reg[MULT_W-1:0]);
            rem_reg     <= '0;
            div_cnt_reg <= DIV_CNT_W'(DIV_CYCLES);
        end
        if (cmd.div_step)
        begin
            quo_reg     <= quo_next;
            rem_reg     <= rem_next;
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
        if (cmd.eval)
        begin
            first_reg <= 1'b0;
            if (better)
            begin
                best_delta_reg <= delta;
                best_m_reg     <= am_reg[MULT_W-1:0];
                best_n_reg     <= an_reg[DIV_W-1:0];
                best_cur_reg   <= quo_reg;
            end
            if (cur <= vco_reg)
            begin
                am_reg <= am_reg + 1'b1;
            end
            else
            begin
                an_reg <= an_reg + 1'b1;
            end
        end
    end

    // output register
    logic                   out_valid_reg;
    logic [OUT_DATA_W-1:0]  out_data_reg;
    logic [STAT_W-1:0]      out_status_reg;
    logic [PROD_W-1:0]      achieved;

    assign achieved = best_cur_reg >> r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_status_reg <= code_reg;
            if (code_reg == STATUS_OK)
            begin
                out_data_reg <= {{(KHZ_W-PROD_W){1'b0}}, achieved,
                                 r_reg, best_n_reg, best_m_reg};
            end
            else
            begin
                out_data_reg <= '0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_data   = {{(OUT_TDATA_W-OUT_DATA_W){1'b0}}, out_data_reg};
    assign out_status = out_status_reg;

    assign stat.ovf        = |shifted[SHIFT_W-1:KHZ_W];
    assign stat.need_lower = (r_reg > POST_EXP_MIN) && (vco_reg > vco_max_reg);
    assign stat.out_range  = (vco_reg < vco_min_reg) || (vco_reg > vco_max_reg);
    assign stat.empty      = (mult_min_reg > mult_max_reg) || (div_min_reg > div_max_reg)
                             || (div_min_reg == '0);
    assign stat.walk_done  = (am_reg > {1'b0, mult_max_reg}) || (an_reg > {1'b0, div_max_reg});
    assign stat.div_last   = (div_cnt_reg == DIV_CNT_W'(1));
    assign stat.out_free   = !out_valid_reg || out_ready;

endmodule

### src/pds_checker.sv
// port-level checks for the pll divider search, bound to the top level
module pds_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [pds_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input logic [pds_pkg::STAT_W-1:0]          m_axis_tuser
);
    import pds_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // error results carry all-zero fields
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != STATUS_OK) |-> (m_axis_tdata == '0))
        else $error("error result with nonzero fields");

    // a good result never has a zero divider
    a_ok_div: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == STATUS_OK) |->
            (m_axis_tdata[MULT_W+DIV_W-1:MULT_W] != '0))
        else $error("good result with zero divider");

    // one search at a time: no accept right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted during a search");

endmodule

bind pll_divider_search pds_checker u_pds_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### dv/tb_top.sv
`timescale 1ns / 100ps
// testbench for pll_divider_search: directed limit cases, random searches, result scoreboard
module tb_top;
    import pds_pkg::*;

    localparam int LIMIT_CYCLES = 10_000_000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PAD_W        = OUT_TDATA_W - OUT_DATA_W;

    // tdata layout of a result item, msb first
    typedef struct packed {
        logic [PAD_W-1:0]  pad;
        logic [KHZ_W-1:0]  achieved;
        logic [EXP_W-1:0]  post_exp;
        logic [DIV_W-1:0]  div;
        logic [MULT_W-1:0] mult;
    } pll_word_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        pll_word_t         word;
    } pll_setting_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic [KHZ_W-1:0]       s_axis_tdata  = '0;
    logic                   m_axis_tready = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index     = CFG_REFERENCE;
    logic [KHZ_W-1:0]       cfg_data      = '0;
    logic                   s_axis_tready;
    logic                   m_axis_tvalid;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [STAT_W-1:0]      m_axis_tuser;

    // shadow copy of the limit registers
    logic [REF_W-1:0]  lim_ref      = RST_REFERENCE;
    logic [MULT_W-1:0] lim_mult_min = RST_MULT_MIN;
    logic [MULT_W-1:0] lim_mult_max = RST_MULT_MAX;
    logic [DIV_W-1:0]  lim_div_min  = RST_DIV_MIN;
    logic [DIV_W-1:0]  lim_div_max  = RST_DIV_MAX;
    logic [EXP_W-1:0]  lim_post_exp = RST_POST_EXP;
    logic [KHZ_W-1:0]  lim_vco_min  = RST_VCO_MIN;
    logic [KHZ_W-1:0]  lim_vco_max  = RST_VCO_MAX;

    pll_setting_t pll_queue[$];
    int err_count     = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    pll_divider_search DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic pll_setting_t search_pll(input logic [KHZ_W-1:0] wanted);
        pll_setting_t     res;
        logic [39:0]      scaled;
        logic [EXP_W-1:0] r;
        logic [31:0]      vco, cur, am, an, best_m, best_n;
        logic [32:0]      best_delta, delta;
        res = '0;
        r = lim_post_exp;
        scaled = {8'd0, wanted} << r;
        if (scaled > 40'h00FFFFFFFF)
        begin
            res.status = STATUS_RANGE;
            return res;
        end
        vco = scaled[31:0];
        while (r > POST_EXP_MIN && vco > lim_vco_max)
        begin
            r = r - 1'b1;
            vco = vco >> 1;
        end
        if (vco < lim_vco_min || vco > lim_vco_max)
        begin
            res.status = STATUS_RANGE;
            return res;
        end
        if (lim_mult_min > lim_mult_max || lim_div_min > lim_div_max || lim_div_min == '0)
        begin
            res.status = STATUS_EMPTY;
            return res;
        end
        best_delta = 33'h1_0000_0000;
        best_m = 32'(lim_mult_min);
        best_n = 32'(lim_div_min);
        am = 32'(lim_mult_min);
        an = 32'(lim_div_min);
        // two-pointer walk, first pair with the smallest distance wins
        while (am <= 32'(lim_mult_max) && an <= 32'(lim_div_max))
        begin
            cur = (32'(lim_ref) * am) / an;
            delta = (cur >= vco) ? 33'(cur - vco) : 33'(vco - cur);
            if (delta < best_delta)
            begin
                best_delta = delta;
                best_m = am;
                best_n = an;
            end
            if (cur <= vco)
                am = am + 1;
            else
                an = an + 1;
        end
        cur = (32'(lim_ref) * best_m) / best_n;
        res.status        = STATUS_OK;
        res.word.mult     = best_m[MULT_W-1:0];
        res.word.div      = best_n[DIV_W-1:0];
        res.word.post_exp = r;
        res.word.achieved = cur >> r;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t %s expected %0d actual %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge clk)
    begin : collect
        pll_word_t    got;
        pll_setting_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (pll_queue.size() == 0)
            begin
                $display("%0t unexpected result item, expected none actual tdata %h tuser %0d",
                         $time, m_axis_tdata, m_axis_tuser);
                err_count++;
            end
            else
            begin
                want = pll_queue.pop_front();
                check_field("mult_out", 32'(want.word.mult), 32'(got.mult));
                check_field("div_out", 32'(want.word.div), 32'(got.div));
                check_field("post_exp_out", 32'(want.word.post_exp), 32'(got.post_exp));
                check_field("achieved_khz", want.word.achieved, got.achieved);
                check_field("tdata pad", 32'd0, 32'(got.pad));
                check_field("status", 32'(want.status), 32'(m_axis_tuser));
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic send_wanted(input logic [KHZ_W-1:0] khz);
        pll_setting_t want;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        want = search_pll(khz);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= khz;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        pll_queue.push_back(want);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pll_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KHZ_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic load_limits(input logic [31:0] ref_khz, mmin, mmax, dmin, dmax, pexp,
                               vmin, vmax);
        wait_idle();
        put_reg(CFG_REFERENCE, ref_khz);
        put_reg(CFG_MULT_MIN, mmin);
        put_reg(CFG_MULT_MAX, mmax);
        put_reg(CFG_DIV_MIN, dmin);
        put_reg(CFG_DIV_MAX, dmax);
        put_reg(CFG_POST_EXP, pexp);
        put_reg(CFG_VCO_MIN, vmin);
        put_reg(CFG_VCO_MAX, vmax);
        cfg_we <= 1'b0;
        lim_ref      = ref_khz[REF_W-1:0];
        lim_mult_min = mmin[MULT_W-1:0];
        lim_mult_max = mmax[MULT_W-1:0];
        lim_div_min  = dmin[DIV_W-1:0];
        lim_div_max  = dmax[DIV_W-1:0];
        lim_post_exp = pexp[EXP_W-1:0];
        lim_vco_min  = vmin;
        lim_vco_max  = vmax;
    endtask

    task automatic test_default_limits();
        send_wanted(32'd0);
        send_wanted(32'hFFFF_FFFF);
        send_wanted(32'h2000_0000);    // first value that overflows at r = 3
        send_wanted(32'h1FFF_FFFF);
        send_wanted(32'd16875);        // vco exactly at its minimum
        send_wanted(32'd16874);
        send_wanted(32'd33750);        // vco exactly at its maximum
        send_wanted(32'd25175);
        send_wanted(32'd40000);
        send_wanted(32'd300000);
    endtask

    task automatic test_extreme_limits();
        load_limits(32'd65535, 32'd1, 32'd1023, 32'd1, 32'd255, 32'd7, 32'd0, 32'hFFFF_FFFF);
        send_wanted(32'd0);
        send_wanted(32'h01FF_FFFF);
        send_wanted(32'h0200_0000);
        send_wanted(32'd100000);
        load_limits(32'd1, 32'd1, 32'd1023, 32'd1, 32'd255, 32'd0, 32'd0, 32'hFFFF_FFFF);
        send_wanted(32'hFFFF_FFFF);
        // only pair gives 0 khz, distance is all ones and must still be kept
        load_limits(32'd1, 32'd1, 32'd1, 32'd2, 32'd2, 32'd0, 32'd0, 32'hFFFF_FFFF);
        send_wanted(32'hFFFF_FFFF);
    endtask

    task automatic test_empty_ranges();
        load_limits(32'd14318, 32'd10, 32'd9, 32'd3, 32'd33, 32'd3, 32'd135000, 32'd270000);
        send_wanted(32'd25175);
        send_wanted(32'd0);            // vco check wins over the empty range
        load_limits(32'd14318, 32'd3, 32'd129, 32'd34, 32'd33, 32'd3, 32'd135000, 32'd270000);
        send_wanted(32'd25175);
        load_limits(32'd14318, 32'd3, 32'd129, 32'd0, 32'd33, 32'd3, 32'd135000, 32'd270000);
        send_wanted(32'd25175);
        load_limits(32'd14318, 32'd5, 32'd5, 32'd7, 32'd7, 32'd3, 32'd135000, 32'd270000);
        send_wanted(32'd25175);
    endtask

    task automatic test_random_searches(input int items, input int send_pct, input int recv_pct);
        int          sent;
        int          batch;
        int          span;
        logic [31:0] ref_khz, mmin, mmax, dmin, dmax, pexp, vmin, vmax, wanted;
        sent = 0;
        while (sent < items)
        begin
            wait_idle();
            send_idle_pct = send_pct;
            recv_idle_pct = recv_pct;
            if ($urandom_range(0, 7) == 0)
                ref_khz = $urandom_range(0, 1) ? 32'd1 : 32'd65535;
            else
                ref_khz = $urandom_range(1, 65535);
            // keep the walk short: narrow m and n windows anywhere in the legal range
            mmin = $urandom_range(1, 1023);
            span = $urandom_range(0, 64);
            mmax = (mmin + span > 1023) ? 32'd1023 : mmin + span;
            dmin = $urandom_range(1, 255);
            span = $urandom_range(0, 24);
            dmax = (dmin + span > 255) ? 32'd255 : dmin + span;
            case ($urandom_range(0, 11))
                0: mmax = mmin - 1;
                1: dmax = dmin - 1;
                2: dmin = 0;
                default: ;
            endcase
            pexp = $urandom_range(0, 7);
            vmin = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom_range(0, 1_000_000);
            if ($urandom_range(0, 7) == 0)
                vmax = 32'hFFFF_FFFF;
            else
                vmax = vmin + $urandom_range(0, 4_000_000);
            load_limits(ref_khz, mmin, mmax, dmin, dmax, pexp, vmin, vmax);
            batch = $urandom_range(4, 10);
            for (int i = 0; i < batch && sent < items; i++)
            begin
                // mostly targets that land inside the vco window after scaling
                if ($urandom_range(0, 3) != 0)
                    wanted = $urandom_range(vmax, vmin) >> $urandom_range(0, pexp);
                else
                    wanted = $urandom >> $urandom_range(0, 31);
                send_wanted(wanted);
                sent++;
            end
        end
    endtask

    initial
    begin
        send_idle_pct = 23;
        recv_idle_pct = 67;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_limits();
        test_extreme_limits();
        test_empty_ranges();
        test_random_searches(40, 23, 67);
        test_random_searches(40, 67, 23);
        test_random_searches(39, 0, 0);
        wait_idle();
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("timeout at %0t with %0d results outstanding", $time, pll_queue.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
